// ===== hdl/fhu_pkg.sv =====
package fhu_pkg;

   localparam int FRAC_BITS = 15;
   localparam int GRADE_W = 16;
   localparam int HEDGE_W = 3;

   localparam logic [GRADE_W-1:0] ONE = GRADE_W'(1 << FRAC_BITS);
   localparam logic [GRADE_W-1:0] HALF = GRADE_W'(1 << (FRAC_BITS - 1));

   localparam int SQ_W = 2 * GRADE_W;
   localparam int RAD_W = 2 * GRADE_W;
   localparam int REM_W = GRADE_W + 3;
   localparam int ROOT_DIGITS = RAD_W / 2;
   localparam int ROOT_STAGES = 4;
   localparam int DIGITS_PER_STAGE = ROOT_DIGITS / ROOT_STAGES;

   localparam int PIPE_STAGES = ROOT_STAGES + 1;

   typedef enum logic [HEDGE_W-1:0] {
      HEDGE_NOT       = 3'd0,
      HEDGE_VERY      = 3'd1,
      HEDGE_SOMEWHAT  = 3'd2,
      HEDGE_EXTREMELY = 3'd3,
      HEDGE_INTENSIFY = 3'd4
   } hedge_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [GRADE_W-1:0] root;
      logic [RAD_W-1:0]   rad;
   } root_state_type;

   typedef struct packed {
      logic      valid;
      hedge_type hedge;
   } ctrl_type;

   function automatic root_state_type root_step(root_state_type s);
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      root_state_type r;
      rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         r.rem = rem_sh - trial;
         r.root = {s.root[GRADE_W-2:0], 1'b1};
      end else begin
         r.rem = rem_sh;
         r.root = {s.root[GRADE_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== hdl/fhu_root_stage.sv =====
module fhu_root_stage
   import fhu_pkg::*;
(
   input  logic           clock,
   input  root_state_type state_in,
   output root_state_type state_out
);

   root_state_type step_in [0:DIGITS_PER_STAGE];
   root_state_type state_ff;

   always_comb begin
      step_in[0] = state_in;
      for (int i = 0; i < DIGITS_PER_STAGE; i++) begin
         step_in[i+1] = root_step(step_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= step_in[DIGITS_PER_STAGE];
   end

   assign state_out = state_ff;

endmodule

// ===== hdl/fhu_poly.sv =====
module fhu_poly
   import fhu_pkg::*;
(
   input  logic               clock,
   input  hedge_type          hedge,
   input  logic [GRADE_W-1:0] grade,
   input  logic [GRADE_W-1:0] operand,
   output logic [GRADE_W-1:0] result
);

   logic [SQ_W-1:0]    sq_ff;
   logic [GRADE_W-1:0] y2_ff;
   hedge_type          hedge2_ff;

   logic [GRADE_W-1:0] t_ff;
   logic [GRADE_W-1:0] dbl_ff;
   logic [GRADE_W-1:0] y3_ff;
   hedge_type          hedge3_ff;

   logic [SQ_W-1:0]    cube_ff;
   logic [GRADE_W-1:0] t4_ff;
   logic [GRADE_W-1:0] dbl4_ff;
   logic [GRADE_W-1:0] y4_ff;
   logic               upper4_ff;
   hedge_type          hedge4_ff;

   logic [GRADE_W-1:0] result_in;
   logic [GRADE_W-1:0] result_ff;

   always_ff @(posedge clock) begin
      sq_ff     <= operand * operand;
      y2_ff     <= grade;
      hedge2_ff <= hedge;

      t_ff      <= sq_ff[FRAC_BITS +: GRADE_W];
      dbl_ff    <= sq_ff[FRAC_BITS-1 +: GRADE_W];
      y3_ff     <= y2_ff;
      hedge3_ff <= hedge2_ff;

      cube_ff   <= t_ff * y3_ff;
      t4_ff     <= t_ff;
      dbl4_ff   <= dbl_ff;
      y4_ff     <= y3_ff;
      upper4_ff <= (y3_ff > HALF);
      hedge4_ff <= hedge3_ff;

      result_ff <= result_in;
   end

   always_comb begin
      case (hedge4_ff)
         HEDGE_NOT:       result_in = ONE - y4_ff;
         HEDGE_VERY:      result_in = t4_ff;
         HEDGE_EXTREMELY: result_in = cube_ff[FRAC_BITS +: GRADE_W];
         HEDGE_INTENSIFY: result_in = upper4_ff ? (ONE - dbl4_ff) : dbl4_ff;
         default:         result_in = '0;
      endcase
   end

   assign result = result_ff;

endmodule

// ===== hdl/fuzzy_hedge_unit_top.sv =====
// An accepted beat passes the input registers, then the root stages or poly registers, then the output registers.
// Throughput: one beat per cycle; once busy drops after reset it stays low.
// The depth is set by the sixteen-digit square root, four digits per stage.
// Results cannot be held off by the receiver, so the pipeline never stalls.
// Reset clears all valid bits and sets busy, which drops at the first clock edge after reset is released.
module fuzzy_hedge_unit_top
   import fhu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [HEDGE_W-1:0] req_hedge,
   input  logic [GRADE_W-1:0] req_grade_in,
   output logic               rsp_valid,
   output logic [GRADE_W-1:0] rsp_grade_out,
   output logic               rsp_bad_hedge
);

   logic busy_ff;
   logic accept;

   logic [GRADE_W-1:0] y_sat;
   logic [GRADE_W-1:0] operand_in;
   logic [GRADE_W-1:0] y_ff;
   logic [GRADE_W-1:0] operand_ff;

   ctrl_type ctrl_in;
   ctrl_type ctrl_ff [1:PIPE_STAGES];

   root_state_type root_state [0:ROOT_STAGES];
   logic [GRADE_W-1:0] poly_result;

   logic               rsp_valid_in;
   logic [GRADE_W-1:0] rsp_grade_in;
   logic               rsp_bad_in;
   logic               rsp_valid_ff;
   logic [GRADE_W-1:0] rsp_grade_ff;
   logic               rsp_bad_ff;

   assign accept = start && !busy_ff;

   always_comb begin
      y_sat = (req_grade_in > ONE) ? ONE : req_grade_in;
      if (hedge_type'(req_hedge) == HEDGE_INTENSIFY && y_sat > HALF) begin
         operand_in = ONE - y_sat;
      end else begin
         operand_in = y_sat;
      end
      ctrl_in.valid = accept;
      ctrl_in.hedge = hedge_type'(req_hedge);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 1; i <= PIPE_STAGES; i++) begin
            ctrl_ff[i].valid <= 1'b0;
         end
      end else begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff[1].valid <= ctrl_in.valid;
         for (int i = 2; i <= PIPE_STAGES; i++) begin
            ctrl_ff[i].valid <= ctrl_ff[i-1].valid;
         end
      end
      ctrl_ff[1].hedge <= ctrl_in.hedge;
      for (int i = 2; i <= PIPE_STAGES; i++) begin
         ctrl_ff[i].hedge <= ctrl_ff[i-1].hedge;
      end
      y_ff <= y_sat;
      operand_ff <= operand_in;
      rsp_grade_ff <= rsp_grade_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   always_comb begin
      root_state[0].rem = '0;
      root_state[0].root = '0;
      root_state[0].rad = RAD_W'({y_ff, {FRAC_BITS{1'b0}}});
   end

   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      fhu_root_stage u_stage (
         .clock     (clock),
         .state_in  (root_state[g]),
         .state_out (root_state[g+1])
      );
   end

   fhu_poly u_poly (
      .clock   (clock),
      .hedge   (ctrl_ff[1].hedge),
      .grade   (y_ff),
      .operand (operand_ff),
      .result  (poly_result)
   );

   always_comb begin
      rsp_valid_in = ctrl_ff[PIPE_STAGES].valid;
      rsp_bad_in = 1'b0;
      case (ctrl_ff[PIPE_STAGES].hedge) inside
         HEDGE_SOMEWHAT: rsp_grade_in = root_state[ROOT_STAGES].root;
         HEDGE_NOT, HEDGE_VERY, HEDGE_EXTREMELY, HEDGE_INTENSIFY: rsp_grade_in = poly_result;
         default: begin
            rsp_grade_in = '0;
            rsp_bad_in = 1'b1;
         end
      endcase
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_grade_out = rsp_grade_ff;
   assign rsp_bad_hedge = rsp_bad_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("accepted beat did not produce a result after six cycles");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_hedge) |-> (rsp_grade_out == '0))
      else $error("unknown hedge returned a nonzero grade");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_hedge) |-> (rsp_grade_out <= ONE))
      else $error("modified grade exceeds one");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bad_hedge == ($past(req_hedge, 6) > HEDGE_W'(HEDGE_INTENSIFY))))
      else $error("error flag does not match the hedge code of the beat");
`endif

endmodule

// ===== tb/sv/tb_fuzzy_hedge_unit_top.sv =====
module tb_fuzzy_hedge_unit_top
   import fhu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [HEDGE_W-1:0] HEDGE_UNKNOWN_LO = 3'd5;
   localparam logic [HEDGE_W-1:0] HEDGE_UNKNOWN_HI = 3'd7;
   localparam logic [GRADE_W-1:0] GRADE_MAX = '1;
   localparam int TAIL_CYCLES = 12;

   typedef struct {
      logic [GRADE_W-1:0] grade;
      logic               bad;
   } hedged_grade_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [HEDGE_W-1:0] req_hedge = '0;
   logic [GRADE_W-1:0] req_grade_in = '0;
   logic               rsp_valid;
   logic [GRADE_W-1:0] rsp_grade_out;
   logic               rsp_bad_hedge;

   hedged_grade_type pending_grades[$];
   int               mismatches = 0;

   fuzzy_hedge_unit_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_hedge    (req_hedge),
      .req_grade_in (req_grade_in),
      .rsp_valid    (rsp_valid),
      .rsp_grade_out(rsp_grade_out),
      .rsp_bad_hedge(rsp_bad_hedge)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("FAIL");
      $finish;
   end

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = GRADE_W - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= v) begin
            root = cand;
         end
      end
      return root;
   endfunction

   function automatic hedged_grade_type apply_hedge(input logic [HEDGE_W-1:0] h,
                                                    input logic [GRADE_W-1:0] g);
      longint unsigned  unity;
      longint unsigned  y;
      longint unsigned  r;
      longint unsigned  t;
      longint unsigned  c;
      hedged_grade_type res;
      unity = 64'd1 << FRAC_BITS;
      y = g;
      r = 0;
      res.bad = 1'b0;
      if (y > unity) begin
         y = unity;
      end
      case (h)
         HEDGE_NOT: begin
            r = unity - y;
         end
         HEDGE_VERY: begin
            r = (y * y) >> FRAC_BITS;
         end
         HEDGE_SOMEWHAT: begin
            r = floor_root(y << FRAC_BITS);
         end
         HEDGE_EXTREMELY: begin
            t = (y * y) >> FRAC_BITS;
            r = (t * y) >> FRAC_BITS;
         end
         HEDGE_INTENSIFY: begin
            if (y <= (unity >> 1)) begin
               r = (2 * y * y) >> FRAC_BITS;
            end else begin
               c = unity - y;
               r = unity - ((2 * c * c) >> FRAC_BITS);
            end
         end
         default: begin
            r = 0;
            res.bad = 1'b1;
         end
      endcase
      res.grade = r[GRADE_W-1:0];
      return res;
   endfunction

   function automatic logic [GRADE_W-1:0] pick_grade();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         return GRADE_W'($urandom_range(0, int'(ONE)));
      end else if (sel < 8) begin
         return GRADE_W'($urandom);
      end else begin
         return GRADE_W'($urandom_range(int'(HALF) - 2, int'(HALF) + 2)
                         + ($urandom_range(0, 1) ? int'(HALF) : 0));
      end
   endfunction

   task automatic send_grade(input logic [HEDGE_W-1:0] h, input logic [GRADE_W-1:0] g);
      start <= 1'b1;
      req_hedge <= h;
      req_grade_in <= g;
      do @(posedge clock); while (busy);
      pending_grades.push_back(apply_hedge(h, g));
   endtask

   task automatic idle_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_all_graded();
      start <= 1'b0;
      while (pending_grades.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      hedged_grade_type want;
      if (!reset && rsp_valid) begin
         if (pending_grades.size() == 0) begin
            $error("unexpected beat: grade_out %0d bad_hedge %0d", rsp_grade_out,
                   rsp_bad_hedge);
            mismatches++;
         end else begin
            want = pending_grades.pop_front();
            if (rsp_grade_out !== want.grade) begin
               $error("grade_out: expected %0d, got %0d", want.grade, rsp_grade_out);
               mismatches++;
            end
            if (rsp_bad_hedge !== want.bad) begin
               $error("bad_hedge: expected %0d, got %0d", want.bad, rsp_bad_hedge);
               mismatches++;
            end
         end
      end
   end

   task automatic test_directed_corners();
      for (int h = 0; h < 8; h++) begin
         send_grade(HEDGE_W'(h), ONE);
      end
      send_grade(HEDGE_NOT, '0);
      send_grade(HEDGE_VERY, '0);
      send_grade(HEDGE_SOMEWHAT, '0);
      send_grade(HEDGE_EXTREMELY, '0);
      send_grade(HEDGE_INTENSIFY, '0);
      send_grade(HEDGE_INTENSIFY, HALF);
      send_grade(HEDGE_INTENSIFY, HALF + 1);
      send_grade(HEDGE_SOMEWHAT, 16'd1);
      send_grade(HEDGE_SOMEWHAT, ONE - 1);
      send_grade(HEDGE_VERY, GRADE_MAX);
      send_grade(HEDGE_EXTREMELY, ONE + 1);
      send_grade(HEDGE_NOT, GRADE_MAX);
      send_grade(HEDGE_UNKNOWN_HI, '0);
      send_grade(HEDGE_UNKNOWN_LO, GRADE_MAX);
      send_grade(HEDGE_INTENSIFY, ONE - 1);
   endtask

   task automatic test_random_with_gaps(input int count);
      for (int i = 0; i < count; i++) begin
         send_grade(HEDGE_W'($urandom_range(0, 7)), pick_grade());
         if ($urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 3));
         end
      end
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 20; i++) begin
         send_grade(HEDGE_W'($urandom_range(0, 4)), pick_grade());
      end
      wait_all_graded();
   endtask

   task automatic test_back_to_back(input int count);
      for (int i = 0; i < count; i++) begin
         send_grade(HEDGE_W'($urandom_range(0, 7)), pick_grade());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_with_gaps(900);
      test_drain_pause();
      test_back_to_back(560);
      wait_all_graded();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/fhu_pkg.sv
hdl/fhu_root_stage.sv
hdl/fhu_poly.sv
hdl/fuzzy_hedge_unit_top.sv
tb/sv/tb_fuzzy_hedge_unit_top.sv
